### design/tfs_pkg.sv
// Shared constants, types and byte-order helpers for the timestamp field shifter.
package tfs_pkg;

    localparam logic [31:0] NS_PER_SEC        = 32'd1000000000;
    localparam logic [15:0] MIN_BUFFER_LENGTH = 16'd12;
    localparam logic [63:0] SEC_LIMIT_NS      = 64'd2147483648000000000;
    localparam logic [31:0] RECIP_MULT        = 32'd2305843009;

    typedef enum logic [1:0] {
        ST_SHIFTED     = 2'd0,
        ST_ZERO_KEPT   = 2'd1,
        ST_CLAMPED     = 2'd2,
        ST_NOT_PATCHED = 2'd3
    } status_t;

    typedef struct packed {
        logic        little;
        logic [63:0] raw;
        logic        early;
        status_t     early_status;
        logic        clamped;
        logic        ovf;
    } tag_t;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [31:0] to_host(input logic [31:0] raw, input logic little);
        return little ? raw : swap32(raw);
    endfunction

endpackage

### design/timestamp_field_shifter_core.sv
// Top level: offset register, front and divide pipelines, output formatting register.
// An accepted item word passes four front stages, four divide stages and one output stage, in that order.
// Throughput: one item word per cycle while the result side does not stall.
// A stall on the result side backs up through the valid bits; empty stages keep filling.
// Reset clears every stage valid bit and sets the offset register to zero.
module timestamp_field_shifter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [15:0] msg_length,
    input  logic [7:0]  encap_flags,
    input  logic [63:0] stamp_bytes,
    input  logic        cfg_write_en,
    input  logic [62:0] cfg_write_data,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [63:0] patched_bytes,
    output logic [1:0]  patch_status
);
    import tfs_pkg::*;

    logic signed [62:0] offset_reg;
    logic               front_ready, front_valid;
    tag_t               front_tag;
    logic [60:0]        front_shifted;
    logic               div_ready, div_valid;
    tag_t               div_tag;
    logic [30:0]        div_sec;
    logic [29:0]        div_nsec;
    logic               out_ready;
    logic               out_valid_reg;
    logic [63:0]        out_bytes_reg, out_bytes_next;
    status_t            out_status_reg, out_status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= '0;
        else if (cfg_write_en)
            offset_reg <= $signed(cfg_write_data);
    end

    tfs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (item_valid),
        .in_ready      (front_ready),
        .msg_length    (msg_length),
        .encap_flags   (encap_flags),
        .stamp_bytes   (stamp_bytes),
        .offset_ns     (offset_reg),
        .out_valid     (front_valid),
        .out_ready     (div_ready),
        .out_tag       (front_tag),
        .out_shifted   (front_shifted)
    );

    tfs_divide u_divide (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (front_valid),
        .in_ready   (div_ready),
        .in_tag     (front_tag),
        .in_shifted (front_shifted),
        .out_valid  (div_valid),
        .out_ready  (out_ready),
        .out_tag    (div_tag),
        .out_sec    (div_sec),
        .out_nsec   (div_nsec)
    );

    assign out_ready  = !out_valid_reg || !result_stall;
    assign item_stall = !front_ready;

    always_comb
    begin
        if (div_tag.early)
        begin
            out_bytes_next  = div_tag.raw;
            out_status_next = div_tag.early_status;
        end
        else if (div_tag.ovf)
        begin
            out_bytes_next  = div_tag.raw;
            out_status_next = ST_NOT_PATCHED;
        end
        else
        begin
            out_bytes_next  = {to_host({2'b00, div_nsec}, div_tag.little),
                               to_host({1'b0, div_sec}, div_tag.little)};
            out_status_next = div_tag.clamped ? ST_CLAMPED : ST_SHIFTED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            out_bytes_reg  <= out_bytes_next;
            out_status_reg <= out_status_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign patched_bytes = out_bytes_reg;
    assign patch_status  = out_status_reg;

    a_clamp_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && patch_status == ST_CLAMPED |-> patched_bytes == 64'd0)
        else $error("clamped word not zero");

    a_zero_kept: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && patch_status == ST_ZERO_KEPT |-> patched_bytes == 64'd0)
        else $error("zero stamp word altered");

    a_empty_out_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("input stalled with empty output stage");

endmodule

### design/tfs_front.sv
// Front pipeline: decode stamp, scale seconds, add offset, clamp and range check.
module tfs_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        msg_length,
    input  logic [7:0]         encap_flags,
    input  logic [63:0]        stamp_bytes,
    input  logic signed [62:0] offset_ns,
    output logic               out_valid,
    input  logic               out_ready,
    output tfs_pkg::tag_t      out_tag,
    output logic [60:0]        out_shifted
);
    import tfs_pkg::*;

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic               s1_ready, s2_ready, s3_ready, s4_ready;
    tag_t               s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg;
    tag_t               s1_tag_next, s4_tag_next;
    logic signed [62:0] s1_prod_reg, s1_prod_next;
    logic [31:0]        s1_nsec_reg, s1_nsec_next;
    logic [31:0]        sec_u;
    logic               short_buf;
    logic signed [63:0] s2_total_reg, s2_total_next;
    logic signed [63:0] s3_shifted_reg, s3_shifted_next;
    logic [60:0]        s4_shifted_reg, s4_shifted_next;
    logic               neg;

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        sec_u        = to_host(stamp_bytes[31:0], encap_flags[0]);
        s1_nsec_next = to_host(stamp_bytes[63:32], encap_flags[0]);
        s1_prod_next = 63'($signed(sec_u)) * $signed(63'(NS_PER_SEC));
        short_buf    = msg_length < MIN_BUFFER_LENGTH;
        s1_tag_next.little       = encap_flags[0];
        s1_tag_next.raw          = stamp_bytes;
        s1_tag_next.early        = short_buf || (stamp_bytes == 64'd0);
        s1_tag_next.early_status = short_buf ? ST_NOT_PATCHED : ST_ZERO_KEPT;
        s1_tag_next.clamped      = 1'b0;
        s1_tag_next.ovf          = 1'b0;
    end

    assign s2_total_next   = 64'(s1_prod_reg) + $signed({32'd0, s1_nsec_reg});
    assign s3_shifted_next = s2_total_reg + 64'(offset_ns);

    always_comb
    begin
        neg                 = s3_shifted_reg[63];
        s4_tag_next         = s3_tag_reg;
        s4_tag_next.clamped = neg;
        s4_tag_next.ovf     = !neg && ($unsigned(s3_shifted_reg) >= SEC_LIMIT_NS);
        s4_shifted_next     = neg ? 61'd0 : s3_shifted_reg[60:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_tag_reg  <= s1_tag_next;
            s1_prod_reg <= s1_prod_next;
            s1_nsec_reg <= s1_nsec_next;
        end
        if (s2_ready)
        begin
            s2_tag_reg   <= s1_tag_reg;
            s2_total_reg <= s2_total_next;
        end
        if (s3_ready)
        begin
            s3_tag_reg     <= s2_tag_reg;
            s3_shifted_reg <= s3_shifted_next;
        end
        if (s4_ready)
        begin
            s4_tag_reg     <= s4_tag_next;
            s4_shifted_reg <= s4_shifted_next;
        end
    end

    assign out_valid   = s4_valid_reg;
    assign out_tag     = s4_tag_reg;
    assign out_shifted = s4_shifted_reg;

endmodule

### design/tfs_divide.sv
// Pipelined split of shifted nanoseconds into seconds and nanoseconds by reciprocal multiply.
module tfs_divide (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tfs_pkg::tag_t in_tag,
    input  logic [60:0]   in_shifted,
    output logic          out_valid,
    input  logic          out_ready,
    output tfs_pkg::tag_t out_tag,
    output logic [30:0]   out_sec,
    output logic [29:0]   out_nsec
);
    import tfs_pkg::*;

    logic        d1_valid_reg, d2_valid_reg, d3_valid_reg, d4_valid_reg;
    logic        d1_ready, d2_ready, d3_ready, d4_ready;
    tag_t        d1_tag_reg, d2_tag_reg, d3_tag_reg, d4_tag_reg;
    logic [51:0] x;
    logic [57:0] d1_pph_reg, d1_pph_next, d1_ppl_reg, d1_ppl_next;
    logic [31:0] d1_lo_reg, d2_lo_reg, d3_lo_reg;
    logic [83:0] acc;
    logic [30:0] d2_q_reg, d2_q_next, d3_q_reg;
    logic [31:0] d3_qp_reg, d3_qp_next;
    logic [31:0] rem;
    logic        fix;
    logic [30:0] d4_sec_reg, d4_sec_next;
    logic [29:0] d4_nsec_reg, d4_nsec_next;

    assign d4_ready = !d4_valid_reg || out_ready;
    assign d3_ready = !d3_valid_reg || d4_ready;
    assign d2_ready = !d2_valid_reg || d3_ready;
    assign d1_ready = !d1_valid_reg || d2_ready;
    assign in_ready = d1_ready;

    assign x           = in_shifted[60:9];
    assign d1_pph_next = 58'(x[51:26]) * 58'(RECIP_MULT);
    assign d1_ppl_next = 58'(x[25:0]) * 58'(RECIP_MULT);

    assign acc       = {d1_pph_reg, 26'd0} + 84'(d1_ppl_reg);
    assign d2_q_next = acc[82:52];

    assign d3_qp_next = {1'b0, d2_q_reg} * NS_PER_SEC;

    always_comb
    begin
        rem          = d3_lo_reg - d3_qp_reg;
        fix          = rem >= NS_PER_SEC;
        d4_sec_next  = d3_q_reg + 31'(fix);
        d4_nsec_next = fix ? 30'(rem - NS_PER_SEC) : rem[29:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
            d3_valid_reg <= 1'b0;
            d4_valid_reg <= 1'b0;
        end
        else
        begin
            if (d1_ready)
                d1_valid_reg <= in_valid;
            if (d2_ready)
                d2_valid_reg <= d1_valid_reg;
            if (d3_ready)
                d3_valid_reg <= d2_valid_reg;
            if (d4_ready)
                d4_valid_reg <= d3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d1_ready)
        begin
            d1_tag_reg <= in_tag;
            d1_pph_reg <= d1_pph_next;
            d1_ppl_reg <= d1_ppl_next;
            d1_lo_reg  <= in_shifted[31:0];
        end
        if (d2_ready)
        begin
            d2_tag_reg <= d1_tag_reg;
            d2_q_reg   <= d2_q_next;
            d2_lo_reg  <= d1_lo_reg;
        end
        if (d3_ready)
        begin
            d3_tag_reg <= d2_tag_reg;
            d3_q_reg   <= d2_q_reg;
            d3_qp_reg  <= d3_qp_next;
            d3_lo_reg  <= d2_lo_reg;
        end
        if (d4_ready)
        begin
            d4_tag_reg  <= d3_tag_reg;
            d4_sec_reg  <= d4_sec_next;
            d4_nsec_reg <= d4_nsec_next;
        end
    end

    assign out_valid = d4_valid_reg;
    assign out_tag   = d4_tag_reg;
    assign out_sec   = d4_sec_reg;
    assign out_nsec  = d4_nsec_reg;

    a_nsec_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        d4_valid_reg |-> (32'(d4_nsec_reg) < NS_PER_SEC))
        else $error("nanoseconds not normalized");

    a_estimate_within_one: assert property (@(posedge clk) disable iff (!rst_n)
        d3_valid_reg && !d3_tag_reg.ovf |-> ((d3_lo_reg - d3_qp_reg) < {NS_PER_SEC[30:0], 1'b0}))
        else $error("quotient estimate off by more than one");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        d3_valid_reg && !d3_ready |=> d3_valid_reg && $stable(d3_q_reg))
        else $error("stalled stage lost its word");

endmodule

### tb/timestamp_field_shifter_core_tb.sv
// Self-checking testbench for the timestamp field shifter core: directed table, then random words.
module timestamp_field_shifter_core_tb;
    import tfs_pkg::*;

    localparam longint NSEC    = 64'sd1000000000;
    localparam longint SEC_MAX = 64'sd2147483647;
    localparam longint OFS_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam longint OFS_MIN = 64'shC000_0000_0000_0000;
    localparam int     PHASES  = 6;
    localparam int     PHASE_WORDS = 275;

    typedef struct packed {
        logic [63:0] bytes;
        status_t     status;
    } patch_t;

    typedef struct packed {
        longint      ofs;
        logic [15:0] len;
        logic [7:0]  flags;
        logic [63:0] bytes;
        bit          typed;
        logic [63:0] exp_bytes;
        status_t     exp_status;
    } vector_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [15:0] msg_length = '0;
    logic [7:0]  encap_flags = '0;
    logic [63:0] stamp_bytes = '0;
    logic        cfg_write_en = 1'b0;
    logic [62:0] cfg_write_data = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [63:0] patched_bytes;
    logic [1:0]  patch_status;

    logic        hold_on = 1'b0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          mismatches = 0;
    longint      cur_offset = 0;
    patch_t      pending_patches[$];

    vector_t directed [0:21] = '{
        '{64'sd0, 16'd0, 8'h01, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
          64'hFFFF_FFFF_FFFF_FFFF, ST_NOT_PATCHED},
        '{64'sd0, 16'd11, 8'h00, 64'h1234_5678_9ABC_DEF0, 1'b1,
          64'h1234_5678_9ABC_DEF0, ST_NOT_PATCHED},
        '{64'sd0, 16'd12, 8'h01, 64'h0, 1'b1, 64'h0, ST_ZERO_KEPT},
        '{64'sd0, 16'd65535, 8'hFE, 64'h0, 1'b1, 64'h0, ST_ZERO_KEPT},
        '{64'sd0, 16'd12, 8'h01, 64'h0000_0000_0000_0001, 1'b1,
          64'h0000_0000_0000_0001, ST_SHIFTED},
        '{64'sd0, 16'd12, 8'h00, 64'h0500_0000_0100_0000, 1'b0, 64'h0, ST_SHIFTED},
        '{64'sd0, 16'd200, 8'h01, 64'hFFFF_FFFF_0000_0000, 1'b0, 64'h0, ST_SHIFTED},
        '{64'sd0, 16'd12, 8'h01, 64'h0000_0000_FFFF_FFFF, 1'b1, 64'h0, ST_CLAMPED},
        '{64'sd0, 16'd12, 8'h00, 64'h0000_0000_0000_0080, 1'b1, 64'h0, ST_CLAMPED},
        '{64'sd0, 16'd12, 8'h01, 64'h3B9A_C9FF_7FFF_FFFF, 1'b0, 64'h0, ST_SHIFTED},
        '{64'sd0, 16'd12, 8'h01, 64'hFFFF_FFFF_7FFF_FFFF, 1'b1,
          64'hFFFF_FFFF_7FFF_FFFF, ST_NOT_PATCHED},
        '{64'sd0, 16'd12, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0, ST_SHIFTED},
        '{OFS_MAX, 16'd12, 8'h01, 64'h0000_0000_0000_0001, 1'b1,
          64'h0000_0000_0000_0001, ST_NOT_PATCHED},
        '{OFS_MAX, 16'd12, 8'h00, 64'h0, 1'b1, 64'h0, ST_ZERO_KEPT},
        '{OFS_MAX, 16'd11, 8'h01, 64'hDEAD_BEEF_0000_0001, 1'b1,
          64'hDEAD_BEEF_0000_0001, ST_NOT_PATCHED},
        '{OFS_MAX, 16'd12, 8'h00, 64'h0000_0000_0000_0080, 1'b0, 64'h0, ST_SHIFTED},
        '{OFS_MIN, 16'd12, 8'h01, 64'hFFFF_FFFF_7FFF_FFFF, 1'b1, 64'h0, ST_CLAMPED},
        '{OFS_MIN, 16'd12, 8'h00, 64'h0100_0000_0000_0000, 1'b1, 64'h0, ST_CLAMPED},
        '{OFS_MIN, 16'd65535, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0, ST_SHIFTED},
        '{-64'sd1, 16'd12, 8'h01, 64'h0000_0001_0000_0000, 1'b0, 64'h0, ST_SHIFTED},
        '{-64'sd1, 16'd12, 8'h01, 64'h0000_0000_0000_0001, 1'b0, 64'h0, ST_SHIFTED},
        '{64'sd1, 16'd12, 8'h01, 64'h3B9A_C9FF_0000_0000, 1'b0, 64'h0, ST_SHIFTED}
    };

    timestamp_field_shifter_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .msg_length     (msg_length),
        .encap_flags    (encap_flags),
        .stamp_bytes    (stamp_bytes),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .patched_bytes  (patched_bytes),
        .patch_status   (patch_status)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] byte_rev(input logic [31:0] w);
        logic [31:0] r;
        r = {<<8{w}};
        return r;
    endfunction

    function automatic logic [63:0] pack_stamp(input logic [31:0] sec, input logic [31:0] ns,
                                               input logic little);
        if (little)
            return {ns, sec};
        return {byte_rev(ns), byte_rev(sec)};
    endfunction

    function automatic patch_t shift_stamp(input logic [15:0] len, input logic [7:0] flags,
                                           input logic [63:0] bytes, input longint ofs);
        patch_t      res;
        logic [31:0] sec_w;
        logic [31:0] ns_w;
        longint      sum;
        longint      q;
        longint      r;
        bit          clamped;
        res.bytes  = bytes;
        res.status = ST_NOT_PATCHED;
        if (len < 16'd12)
            return res;
        sec_w = flags[0] ? bytes[31:0] : byte_rev(bytes[31:0]);
        ns_w  = flags[0] ? bytes[63:32] : byte_rev(bytes[63:32]);
        if (sec_w == '0 && ns_w == '0)
        begin
            res.status = ST_ZERO_KEPT;
            return res;
        end
        sum = longint'($signed(sec_w)) * NSEC + longint'({32'd0, ns_w}) + ofs;
        clamped = sum < 0;
        if (clamped)
            sum = 0;
        q = sum / NSEC;
        r = sum % NSEC;
        if (q > SEC_MAX)
            return res;
        res.bytes  = pack_stamp(q[31:0], r[31:0], flags[0]);
        res.status = clamped ? ST_CLAMPED : ST_SHIFTED;
        return res;
    endfunction

    function automatic longint full_offset();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return {w[62], w[62:0]};
    endfunction

    function automatic longint near_offset();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return {{24{w[39]}}, w[39:0]};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h", what, got, want);
        mismatches++;
    endtask

    task automatic drain();
        while (pending_patches.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_offset(input longint ofs);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= ofs[62:0];
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cur_offset = ofs;
    endtask

    task automatic send_word(input logic [15:0] len, input logic [7:0] flags,
                             input logic [63:0] bytes, input bit typed, input patch_t want);
        msg_length  <= len;
        encap_flags <= flags;
        stamp_bytes <= bytes;
        item_valid  <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_patches.insert(pending_patches.size(),
                               typed ? want : shift_stamp(len, flags, bytes, cur_offset));
    endtask

    task automatic send_random();
        logic [15:0] len;
        logic [7:0]  flags;
        logic [31:0] sec;
        logic [31:0] ns;
        logic [63:0] bytes;
        int          pick;
        patch_t      none;
        none  = '0;
        flags = 8'($urandom);
        pick  = $urandom_range(0, 99);
        if (pick < 6)
            len = 16'($urandom_range(0, 11));
        else if (pick < 9)
            len = 16'hFFFF;
        else
            len = 16'($urandom_range(12, 65535));
        pick = $urandom_range(0, 99);
        sec  = $urandom;
        ns   = $urandom;
        if (pick < 5)
        begin
            sec = '0;
            ns  = '0;
        end
        else if (pick inside {[30:69]})
            ns = $urandom_range(0, 999999999);
        else if (pick inside {[70:84]})
            sec = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 8)
                                       : 32'h8000_0000 + $urandom_range(0, 8);
        else if (pick >= 85)
            sec = $urandom_range(0, 200) - 100;
        bytes = (pick inside {[5:29]}) ? {$urandom, $urandom} : pack_stamp(sec, ns, flags[0]);
        send_word(len, flags, bytes, 1'b0, none);
    endtask

    task automatic hold_results(input int cycles);
        hold_on <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_on <= 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= hold_on || ($urandom_range(0, 99) < rx_idle_pct);
    end

    always @(posedge clk)
    begin
        patch_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_patches.size() == 0)
                report_mismatch("unexpected word", patched_bytes, 64'h0);
            else
            begin
                want = pending_patches.pop_front();
                if (patched_bytes !== want.bytes)
                    report_mismatch("patched_bytes", patched_bytes, want.bytes);
                if (patch_status !== want.status)
                    report_mismatch("patch_status", {62'd0, patch_status}, {62'd0, want.status});
            end
        end
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        patch_t want;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].ofs != cur_offset)
            begin
                item_valid <= 1'b0;
                set_offset(directed[i].ofs);
            end
            want.bytes  = directed[i].exp_bytes;
            want.status = directed[i].exp_status;
            send_word(directed[i].len, directed[i].flags, directed[i].bytes,
                      directed[i].typed, want);
        end
        item_valid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0, 3: set_offset(near_offset());
                1, 5: set_offset(full_offset());
                2: set_offset(OFS_MIN);
                default: set_offset(OFS_MAX);
            endcase
            case (p / 2)
                0:
                begin
                    tx_idle_pct = 7;
                    rx_idle_pct = 56;
                end
                1:
                begin
                    tx_idle_pct = 56;
                    rx_idle_pct = 7;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if ((p == 0 || p == 4) && n == 100)
                    fork
                        hold_results(400);
                    join_none
                if (p == 3 && n == 140)
                begin
                    item_valid <= 1'b0;
                    @(posedge clk);
                    while (pending_patches.size() != 0)
                        @(posedge clk);
                end
                while ($urandom_range(0, 99) < tx_idle_pct)
                begin
                    item_valid <= 1'b0;
                    @(posedge clk);
                end
                send_random();
            end
            item_valid <= 1'b0;
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
design/tfs_pkg.sv
design/tfs_front.sv
design/tfs_divide.sv
design/timestamp_field_shifter_core.sv
tb/timestamp_field_shifter_core_tb.sv
